@@ rtl/box_filter_3x3_rgba_core_macros.svh @@
// assertion macros shared by the box filter rtl
`ifndef BOX_FILTER_3X3_RGBA_CORE_MACROS_SVH
`define BOX_FILTER_3X3_RGBA_CORE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define BF3_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define BF3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bf3_pkg.sv @@
// shared types, constants and helpers of the 3x3 box filter
`default_nettype none

package bf3_pkg;

	// image geometry
	localparam int DIM_MAX = 1024;
	localparam int DIM_W   = 11;
	localparam int POS_W   = $clog2(DIM_MAX);

	// pixel and arithmetic widths
	localparam int CH_W     = 16;
	localparam int CH_N     = 4;
	localparam int PIX_W    = CH_N * CH_W;
	localparam int SUM_W    = CH_W + 4;
	localparam int CNT_W    = 4;
	localparam int RECIP_SH = SUM_W + 4;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int PROD_W   = SUM_W + RECIP_W;

	localparam logic [DIM_W-1:0] DIM_MAX_V = DIM_W'(DIM_MAX);

	// rounded-up reciprocals, exact for any sum below 2**SUM_W
	localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(2 ** RECIP_SH);
	localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((2 ** RECIP_SH + 1) / 2);
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2 ** RECIP_SH + 2) / 3);
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2 ** RECIP_SH + 3) / 4);
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2 ** RECIP_SH + 5) / 6);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2 ** RECIP_SH + 8) / 9);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [PIX_W-1:0] pix_t;

	// 3x3 neighborhood, entry 3*row+col, row 0 on top, col 0 on the left
	typedef struct packed {
		pix_t [8:0]       px;
		logic [8:0]       mask;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} win_t;

	// reciprocal of a neighborhood size
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			CNT_W'(2): r = RECIP_2;
			CNT_W'(3): r = RECIP_3;
			CNT_W'(4): r = RECIP_4;
			CNT_W'(6): r = RECIP_6;
			CNT_W'(9): r = RECIP_9;
			default:   r = RECIP_1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bf3_avg.sv @@
// masked 3x3 sums and division by the neighborhood size, with output register
`default_nettype none

module bf3_avg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             win_valid,
	output logic                  win_ready,
	input  wire bf3_pkg::win_t    win,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [bf3_pkg::CH_W-1:0] out_red,
	output logic [bf3_pkg::CH_W-1:0] out_green,
	output logic [bf3_pkg::CH_W-1:0] out_blue,
	output logic [bf3_pkg::CH_W-1:0] out_alpha,
	output logic                  frame_last
);

`include "box_filter_3x3_rgba_core_macros.svh"

	// stage registers
	logic                              valid_s2;
	bf3_pkg::win_t                     win_s2;
	logic                              valid_s3;
	logic [bf3_pkg::SUM_W-1:0]         sum_s3 [bf3_pkg::CH_N];
	logic [bf3_pkg::RECIP_W-1:0]       recip_s3;
	logic                              last_s3;
	logic                              out_valid_q;
	bf3_pkg::pix_t                     out_pix_q;
	logic                              out_last_q;

	logic                              out_free;
	logic                              s3_open;
	logic                              s2_open;
	bf3_pkg::pix_t                     mpx [9];
	logic [bf3_pkg::SUM_W-1:0]         row_sum [bf3_pkg::CH_N][3];
	logic [bf3_pkg::SUM_W-1:0]         sum_d [bf3_pkg::CH_N];
	logic [bf3_pkg::PROD_W-1:0]        prod [bf3_pkg::CH_N];
	bf3_pkg::pix_t                     quot;
	logic                              quot_ovf;

	// stall chain from the output side
	assign out_free  = !out_valid_q || out_ready;
	assign s3_open   = !valid_s3 || out_free;
	assign s2_open   = !valid_s2 || s3_open;
	assign win_ready = s2_open;

	// masked sums: each row of three, then the three row sums
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			mpx[i] = win_s2.mask[i] ? win_s2.px[i] : '0;
		end
		for (int k = 0; k < bf3_pkg::CH_N; k++) begin
			for (int r = 0; r < 3; r++) begin
				row_sum[k][r] = bf3_pkg::SUM_W'(mpx[3*r][bf3_pkg::CH_W*k +: bf3_pkg::CH_W])
					+ bf3_pkg::SUM_W'(mpx[3*r+1][bf3_pkg::CH_W*k +: bf3_pkg::CH_W])
					+ bf3_pkg::SUM_W'(mpx[3*r+2][bf3_pkg::CH_W*k +: bf3_pkg::CH_W]);
			end
			sum_d[k] = row_sum[k][0] + row_sum[k][1] + row_sum[k][2];
		end
	end

	// quotient by reciprocal multiply
	always_comb begin
		quot_ovf = 1'b0;
		for (int k = 0; k < bf3_pkg::CH_N; k++) begin
			prod[k] = bf3_pkg::PROD_W'(sum_s3[k]) * bf3_pkg::PROD_W'(recip_s3);
			quot[bf3_pkg::CH_W*k +: bf3_pkg::CH_W] =
				prod[k][bf3_pkg::RECIP_SH +: bf3_pkg::CH_W];
			quot_ovf = quot_ovf
				|| (prod[k][bf3_pkg::PROD_W-1:bf3_pkg::RECIP_SH+bf3_pkg::CH_W] != '0);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_open) begin
				valid_s2 <= win_valid;
			end
			if (s3_open) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (win_valid && s2_open) begin
			win_s2 <= win;
		end
		if (valid_s2 && s3_open) begin
			sum_s3   <= sum_d;
			recip_s3 <= bf3_pkg::recip(win_s2.cnt);
			last_s3  <= win_s2.last;
		end
		if (valid_s3 && out_free) begin
			out_pix_q  <= quot;
			out_last_q <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q[0*bf3_pkg::CH_W +: bf3_pkg::CH_W];
	assign out_green  = out_pix_q[1*bf3_pkg::CH_W +: bf3_pkg::CH_W];
	assign out_blue   = out_pix_q[2*bf3_pkg::CH_W +: bf3_pkg::CH_W];
	assign out_alpha  = out_pix_q[3*bf3_pkg::CH_W +: bf3_pkg::CH_W];
	assign frame_last = out_last_q;

	// checks
	`BF3_ASSERT_NOW(a_cnt_matches_mask, valid_s2, bf3_pkg::CNT_W'($countones(win_s2.mask)) == win_s2.cnt, "neighborhood size disagrees with mask")
	`BF3_ASSERT_NOW(a_center_taken, valid_s2, win_s2.mask[4] || (win_s2.cnt == bf3_pkg::CNT_W'(1)), "center pixel missing from neighborhood")
	`BF3_ASSERT_NOW(a_mean_in_range, valid_s3, !quot_ovf, "mean exceeds channel range")

endmodule

`default_nettype wire

@@ rtl/box_filter_3x3_rgba_core.sv @@
// top level of the 3x3 box filter over a square rgba image
`default_nettype none

// Streams a square RGBA image (16-bit channels) in raster order and returns,
// per pixel, the truncated per-channel mean of the in-image part of its 3x3
// neighborhood. One word is accepted per clock cycle unless the output stalls,
// drain words included; the rate is set by the single column memory (1024 x
// 128 bits, one read and one write per word: the two rows above the incoming
// pixel at its column), plus a window register of two columns of three. The
// result, registered in the first stage and the averager, follows the word
// completing its neighborhood, one row plus one pixel after the pixel; after
// the frame's last pixel, size+1 drain words (op = 1) flush the tail and the
// final result carries frame_last. Pixels that arrive while a tail is pending
// and drains with no tail pending are taken and dropped. A write of image_dim
// (0 acts as 1, above 1024 acts as 1024) restarts the frame and may be issued
// only while the block is idle. The memory needs no clearing: entries left
// from earlier frames fall outside the image and are masked.
module box_filter_3x3_rgba_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [bf3_pkg::DIM_W-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      op,
	input  wire logic [bf3_pkg::CH_W-1:0]  in_red,
	input  wire logic [bf3_pkg::CH_W-1:0]  in_green,
	input  wire logic [bf3_pkg::CH_W-1:0]  in_blue,
	input  wire logic [bf3_pkg::CH_W-1:0]  in_alpha,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [bf3_pkg::CH_W-1:0]       out_red,
	output logic [bf3_pkg::CH_W-1:0]       out_green,
	output logic [bf3_pkg::CH_W-1:0]       out_blue,
	output logic [bf3_pkg::CH_W-1:0]       out_alpha,
	output logic                           frame_last
);

`include "box_filter_3x3_rgba_core_macros.svh"

	localparam int PW = bf3_pkg::PIX_W;

	// frame position state
	logic [bf3_pkg::POS_W-1:0] dm1_q;
	logic [bf3_pkg::POS_W-1:0] in_row_q;
	logic [bf3_pkg::POS_W-1:0] in_col_q;
	logic [bf3_pkg::POS_W-1:0] out_row_q;
	logic [bf3_pkg::POS_W-1:0] out_col_q;
	logic                      in_done_q;

	// column memory and window
	logic [2*PW-1:0]           mem [bf3_pkg::DIM_MAX];
	logic [2*PW-1:0]           rd_q;
	bf3_pkg::pix_t [2:0]       win1_q;
	bf3_pkg::pix_t [2:0]       win2_q;

	// first stage
	logic                      valid_s1;
	logic [bf3_pkg::POS_W-1:0] col_s1;
	bf3_pkg::pix_t             cur_s1;
	logic [8:0]                mask_s1;
	logic [bf3_pkg::CNT_W-1:0] cnt_s1;
	logic                      last_s1;
	logic                      prod_s1;
	logic                      fwd_s1;
	logic [2*PW-1:0]           fwd_data_s1;

	logic [bf3_pkg::DIM_W-1:0] dim_eff;
	logic [bf3_pkg::POS_W-1:0] dm1_d;
	logic                      accept;
	logic                      step_px;
	logic                      step_dr;
	logic                      step;
	logic                      step_out;
	logic                      px_prod;
	logic                      in_last_col;
	logic                      in_last_row;
	logic                      out_last_col;
	logic                      out_last;
	logic [bf3_pkg::POS_W-1:0] vcol;
	logic                      top_ok;
	logic                      bot_ok;
	logic                      lft_ok;
	logic                      rgt_ok;
	logic [2:0]                row_ok;
	logic [2:0]                col_ok;
	logic [1:0]                rows_n;
	logic [1:0]                cols_n;
	logic [8:0]                mask_d;
	logic [bf3_pkg::CNT_W-1:0] cnt_d;
	logic [2*PW-1:0]           rd_eff;
	logic [2*PW-1:0]           wr_data;
	bf3_pkg::pix_t [2:0]       triple;
	bf3_pkg::win_t             win_d;
	logic                      avg_ready;
	logic                      s1_retire;
	logic                      s1_open;

	// size clamp on write
	always_comb begin
		if (cfg_wr_data == '0) begin
			dim_eff = bf3_pkg::DIM_W'(1);
		end else if (cfg_wr_data > bf3_pkg::DIM_MAX_V) begin
			dim_eff = bf3_pkg::DIM_MAX_V;
		end else begin
			dim_eff = cfg_wr_data;
		end
		dm1_d = bf3_pkg::POS_W'(dim_eff - bf3_pkg::DIM_W'(1));
	end

	// word classification
	assign accept   = in_valid && in_ready;
	assign step_px  = accept && (op == bf3_pkg::OP_PIXEL) && !in_done_q;
	assign step_dr  = accept && (op == bf3_pkg::OP_DRAIN) && in_done_q;
	assign step     = step_px || step_dr;
	assign px_prod  = (in_row_q > bf3_pkg::POS_W'(1))
		|| ((in_row_q == bf3_pkg::POS_W'(1)) && (in_col_q != '0));
	assign step_out = (step_px && px_prod) || step_dr;

	assign in_last_col  = (in_col_q == dm1_q);
	assign in_last_row  = (in_row_q == dm1_q);
	assign out_last_col = (out_col_q == dm1_q);
	assign out_last     = out_last_col && (out_row_q == dm1_q);

	// column of the word entering the window
	always_comb begin
		if (op == bf3_pkg::OP_PIXEL) begin
			vcol = in_col_q;
		end else if (out_last_col) begin
			vcol = '0;
		end else begin
			vcol = out_col_q + bf3_pkg::POS_W'(1);
		end
	end

	// neighborhood mask and size of the result due
	always_comb begin
		top_ok = (out_row_q != '0);
		bot_ok = (out_row_q != dm1_q);
		lft_ok = (out_col_q != '0);
		rgt_ok = !out_last_col;
		row_ok = {bot_ok, 1'b1, top_ok};
		col_ok = {rgt_ok, 1'b1, lft_ok};
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask_d[3*r+c] = row_ok[r] && col_ok[c];
			end
		end
		// size one: the pixel sits at the bottom of the middle column
		if (dm1_q == '0) begin
			mask_d        = '0;
			mask_d[3*2+1] = 1'b1;
		end
		rows_n = 2'd1 + 2'(top_ok) + 2'(bot_ok);
		cols_n = 2'd1 + 2'(lft_ok) + 2'(rgt_ok);
		cnt_d  = {2'b00, rows_n} * {2'b00, cols_n};
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm1_q     <= bf3_pkg::POS_W'(bf3_pkg::DIM_MAX - 1);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_done_q <= 1'b0;
		end else if (cfg_wr_en) begin
			dm1_q     <= dm1_d;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_done_q <= 1'b0;
		end else begin
			if (step_px) begin
				if (in_last_col) begin
					in_col_q <= '0;
					if (in_last_row) begin
						in_row_q  <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + bf3_pkg::POS_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + bf3_pkg::POS_W'(1);
				end
			end
			if (step_out) begin
				if (out_last) begin
					out_row_q <= '0;
					out_col_q <= '0;
				end else if (out_last_col) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + bf3_pkg::POS_W'(1);
				end else begin
					out_col_q <= out_col_q + bf3_pkg::POS_W'(1);
				end
			end
			if (step_dr && out_last) begin
				in_done_q <= 1'b0;
			end
		end
	end

	// memory word forwarded when the entry is written on the read edge
	assign rd_eff  = fwd_s1 ? fwd_data_s1 : rd_q;
	assign wr_data = {rd_eff[PW-1:0], cur_s1};
	assign triple  = {cur_s1, rd_eff[PW-1:0], rd_eff[2*PW-1:PW]};

	// stall chain
	assign s1_retire = valid_s1 && (!prod_s1 || avg_ready);
	assign s1_open   = !valid_s1 || s1_retire;
	assign in_ready  = s1_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_open) begin
			valid_s1 <= step;
		end
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (step) begin
			col_s1      <= vcol;
			cur_s1      <= {in_alpha, in_blue, in_green, in_red};
			mask_s1     <= mask_d;
			cnt_s1      <= cnt_d;
			last_s1     <= out_last;
			prod_s1     <= step_out;
			fwd_s1      <= s1_retire && (col_s1 == vcol);
			fwd_data_s1 <= wr_data;
		end
	end

	// column memory: read on entry, write back as the word moves on
	always_ff @(posedge clk) begin
		if (step) begin
			rd_q <= mem[vcol];
		end
		if (s1_retire) begin
			mem[col_s1] <= wr_data;
		end
	end

	// window shift
	always_ff @(posedge clk) begin
		if (s1_retire) begin
			win1_q <= win2_q;
			win2_q <= triple;
		end
	end

	// neighborhood handed to the averager
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_d.px[3*r]   = win1_q[r];
			win_d.px[3*r+1] = win2_q[r];
			win_d.px[3*r+2] = triple[r];
		end
		win_d.mask = mask_s1;
		win_d.cnt  = cnt_s1;
		win_d.last = last_s1;
	end

	bf3_avg u_avg (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (valid_s1 && prod_s1),
		.win_ready  (avg_ready),
		.win        (win_d),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha),
		.frame_last (frame_last)
	);

	// checks
	`BF3_ASSERT_NOW(a_done_at_origin, in_done_q, (in_row_q == '0) && (in_col_q == '0), "input position not at origin while tail pending")
	`BF3_ASSERT_NEXT(a_last_drain_rearms, step_dr && out_last && !cfg_wr_en, !in_done_q && (out_row_q == '0) && (out_col_q == '0), "frame not rearmed after last drain")
	`BF3_ASSERT_NOW(a_col_in_image, step, vcol <= dm1_q, "window column outside image")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench of the 3x3 rgba box filter core
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bf3_pkg::*;

	localparam int RING_MAX      = 2 * DIM_MAX + 2;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_WORDS  = 200;
	localparam int CLAMP_WORDS   = 64;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic            last;
	} filt_res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [DIM_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	op_t op;
	logic [CH_W-1:0] in_red, in_green, in_blue, in_alpha;
	logic out_valid;
	logic out_ready;
	logic [CH_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic frame_last;

	// filter state as predicted from the words accepted so far
	logic [DIM_W-1:0] dim_reg;
	pix_t ring_px [RING_MAX];
	int unsigned row_in, col_in, row_out, col_out, ring_wr;
	bit tail_pending;
	filt_res_t mean_q [$];

	bit gaps_on;
	int unsigned words_sent, pixels_checked, frames_done, fail_count;

	box_filter_3x3_rgba_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.in_alpha   (in_alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha),
		.frame_last (frame_last)
	);

	always #1 clk = ~clk;

	// effective image side, register clamped to 1..DIM_MAX
	function automatic int unsigned side_len();
		int unsigned d;
		d = 32'(dim_reg);
		if (d < 1) d = 1;
		if (d > DIM_MAX) d = DIM_MAX;
		return d;
	endfunction

	// pixel at linear index x, nw pixels of this frame already stored
	function automatic pix_t window_px(input int unsigned x, input int unsigned nw,
			input int unsigned len, input pix_t cur);
		int unsigned back;
		if (x >= nw) return cur;
		back = nw - x;
		if (back > len) return '0;
		return ring_px[(ring_wr + len - back) % len];
	endfunction

	// mean of the in-image neighborhood of the next output position
	task automatic push_mean(input int unsigned d, input int unsigned nw, input pix_t cur);
		int unsigned len, r0, r1, c0, c1, cnt, r, c, k;
		int unsigned sum [4];
		pix_t p;
		filt_res_t res;
		len = 2 * d + 2;
		r0 = row_out > 0 ? row_out - 1 : 0;
		r1 = row_out + 1 < d ? row_out + 1 : d - 1;
		c0 = col_out > 0 ? col_out - 1 : 0;
		c1 = col_out + 1 < d ? col_out + 1 : d - 1;
		for (k = 0; k < 4; k++) sum[k] = 0;
		cnt = 0;
		for (r = r0; r <= r1; r++) begin
			for (c = c0; c <= c1; c++) begin
				p = window_px(r * d + c, nw, len, cur);
				for (k = 0; k < 4; k++) sum[k] += 32'(p[CH_W*k +: CH_W]);
				cnt++;
			end
		end
		if (cnt == 0) cnt = 1;
		res.red   = CH_W'(sum[0] / cnt);
		res.green = CH_W'(sum[1] / cnt);
		res.blue  = CH_W'(sum[2] / cnt);
		res.alpha = CH_W'(sum[3] / cnt);
		res.last  = (row_out == d - 1) && (col_out == d - 1);
		mean_q.push_back(res);
		col_out++;
		if (col_out >= d) begin
			col_out = 0;
			row_out++;
		end
	endtask

	// advance the predicted state by one accepted word
	task automatic predict_word(input op_t kind, input pix_t px);
		int unsigned d, n;
		d = side_len();
		if (kind == OP_PIXEL) begin
			// pixels between the last pixel and the last output are dropped
			if (tail_pending) return;
			n = row_in * d + col_in;
			if (n >= d + 1) push_mean(d, n, px);
			ring_px[ring_wr] = px;
			ring_wr++;
			if (ring_wr >= 2 * d + 2) ring_wr = 0;
			col_in++;
			if (col_in >= d) begin
				col_in = 0;
				row_in++;
				if (row_in >= d) begin
					row_in = 0;
					tail_pending = 1'b1;
				end
			end
		end else begin
			// drain with no tail pending does nothing
			if (!tail_pending) return;
			push_mean(d, d * d, '0);
			if (mean_q[$].last) begin
				row_out = 0;
				col_out = 0;
				ring_wr = 0;
				tail_pending = 1'b0;
			end
		end
	endtask

	function automatic logic [CH_W-1:0] rand_channel();
		logic [CH_W-1:0] v;
		case ($urandom_range(7))
			0:       v = '0;
			1:       v = '1;
			default: v = CH_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic pix_t rand_pixel();
		return {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
	endfunction

	// present one word, hold it until accepted, then predict
	task automatic send_word(input op_t kind, input pix_t px);
		int unsigned gap;
		gap = gaps_on ? $urandom_range(10) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= kind;
		in_red   <= px[CH_W*0 +: CH_W];
		in_green <= px[CH_W*1 +: CH_W];
		in_blue  <= px[CH_W*2 +: CH_W];
		in_alpha <= px[CH_W*3 +: CH_W];
		do @(posedge clk); while (in_ready !== 1'b1);
		words_sent++;
		predict_word(kind, px);
	endtask

	// stop sending until every predicted word has come out
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (mean_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// size write, restarts the frame
	task automatic cfg_write(input logic [DIM_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		dim_reg = v;
		row_in = 0;
		col_in = 0;
		row_out = 0;
		col_out = 0;
		ring_wr = 0;
		tail_pending = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// size left at reset: top rows of the largest image
	task automatic test_default_size();
		gaps_on = 1'b0;
		repeat (DIM_MAX + 4) send_word(OP_PIXEL, rand_pixel());
		gaps_on = 1'b1;
		wait_results_done();
	endtask

	// size zero and size one: output is the pixel itself on the first drain
	task automatic test_single_pixel();
		cfg_write('0);
		send_word(OP_DRAIN, rand_pixel());
		send_word(OP_PIXEL, '1);
		send_word(OP_PIXEL, rand_pixel());
		send_word(OP_DRAIN, rand_pixel());
		send_word(OP_DRAIN, rand_pixel());
		wait_results_done();
		cfg_write(DIM_W'(1));
		send_word(OP_PIXEL, '0);
		send_word(OP_DRAIN, '1);
		wait_results_done();
	endtask

	// partial frame, later cut short by a size write
	task automatic test_restart();
		cfg_write(DIM_W'(3));
		repeat (6) send_word(OP_PIXEL, rand_pixel());
		wait_results_done();
	endtask

	// full-scale sums and mixed channels on corners and edges
	task automatic test_extremes();
		cfg_write(DIM_W'(3));
		repeat (9) send_word(OP_PIXEL, '1);
		repeat (4) send_word(OP_DRAIN, '0);
		wait_results_done();
		cfg_write(DIM_W'(2));
		send_word(OP_PIXEL, 64'hFFFF_0000_FFFF_0000);
		send_word(OP_PIXEL, 64'h0000_FFFF_0000_FFFF);
		send_word(OP_PIXEL, 64'h0000_0000_FFFF_FFFF);
		send_word(OP_PIXEL, 64'hFFFF_FFFF_0000_0000);
		repeat (4) send_word(OP_DRAIN, rand_pixel());
		wait_results_done();
	endtask

	// all-ones size acts as the maximum: the first row gives no result
	task automatic test_size_clamp();
		cfg_write('1);
		gaps_on = 1'b0;
		repeat (CLAMP_WORDS) send_word(OP_PIXEL, rand_pixel());
		gaps_on = 1'b1;
		wait_results_done();
	endtask

	// random small frames with noise, aborts and dropped pixels
	task automatic test_random_frames();
		int unsigned counted, d, stop_at, k, pick;
		bit restart_due, abort;
		logic [DIM_W-1:0] size_val;
		counted = 0;
		restart_due = 1'b1;
		while (counted < RANDOM_WORDS) begin
			gaps_on = ($urandom_range(3) != 0);
			if (restart_due || $urandom_range(9) < 7) begin
				wait_results_done();
				pick = $urandom_range(19);
				if (pick < 12) size_val = DIM_W'($urandom_range(6, 1));
				else if (pick < 17) size_val = DIM_W'($urandom_range(12, 7));
				else if (pick < 19) size_val = DIM_W'($urandom_range(20, 13));
				else size_val = '0;
				cfg_write(size_val);
			end
			d = side_len();
			// drain too early
			if ($urandom_range(4) == 0) send_word(OP_DRAIN, rand_pixel());
			abort = ($urandom_range(9) == 0);
			stop_at = abort ? $urandom_range(d * d - 1) : d * d;
			for (k = 0; k < stop_at; k++) begin
				send_word(OP_PIXEL, rand_pixel());
				counted++;
				if ($urandom_range(39) == 0) wait_results_done();
			end
			restart_due = abort;
			if (!abort) begin
				// tail, with pixels dropped in between
				while (tail_pending) begin
					if ($urandom_range(5) == 0) begin
						send_word(OP_PIXEL, rand_pixel());
					end else begin
						send_word(OP_DRAIN, rand_pixel());
						counted++;
					end
				end
				// drain too late
				if ($urandom_range(4) == 0) send_word(OP_DRAIN, rand_pixel());
			end
		end
		wait_results_done();
	endtask

	// output side: random stalls, compare each word with the oldest prediction
	initial begin : result_check
		int unsigned stall;
		filt_res_t got, want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = gaps_on ? $urandom_range(10) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = {out_red, out_green, out_blue, out_alpha, frame_last};
			if (mean_q.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual %h", $time, got);
				fail_count++;
			end else begin
				want = mean_q.pop_front();
				check_field("out_red", want.red, got.red);
				check_field("out_green", want.green, got.green);
				check_field("out_blue", want.blue, got.blue);
				check_field("out_alpha", want.alpha, got.alpha);
				check_field("frame_last", CH_W'(want.last), CH_W'(got.last));
				pixels_checked++;
				if (got.last) frames_done++;
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main_seq
		int unsigned guard;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		op          <= OP_PIXEL;
		in_red      <= '0;
		in_green    <= '0;
		in_blue     <= '0;
		in_alpha    <= '0;
		gaps_on = 1'b1;
		words_sent = 0;
		pixels_checked = 0;
		frames_done = 0;
		fail_count = 0;
		dim_reg = DIM_MAX_V;
		row_in = 0;
		col_in = 0;
		row_out = 0;
		col_out = 0;
		ring_wr = 0;
		tail_pending = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_size();
		test_single_pixel();
		test_restart();
		test_extremes();
		test_size_clamp();
		test_random_frames();

		// final drain with a limit, no stalls so late words get seen
		gaps_on = 1'b0;
		in_valid <= 1'b0;
		guard = 0;
		while (mean_q.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		if (mean_q.size() != 0) begin
			$display("%0t ns: %0d words missing, expected %h, actual none",
				$time, mean_q.size(), mean_q[0]);
			fail_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d input words, %0d filtered pixels checked, %0d full frames",
			words_sent, pixels_checked, frames_done);
		$display("sizes 1 to %0d incl. clamped writes, restarts, stray drains, dropped pixels",
			DIM_MAX);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
